>>> hw/rtl/round_robin_lock_scheduler_assert.svh
// Assertion macros for the round-robin lock scheduler.
`ifndef ROUND_ROBIN_LOCK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_LOCK_SCHEDULER_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define RRLS_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("rrls assertion failed");

// Check that cond holds in the cycle after trig.
`define RRLS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("rrls assertion failed");

`endif

>>> hw/rtl/rrls_pkg.sv
// Shared types, codes and constants of the round-robin lock scheduler.
package rrls_pkg;

    localparam int MAX_PROCS = 16;
    localparam int MAX_STMTS = 32;
    localparam int NUM_VARS  = 26;

    localparam int STMT_W = 15;

    // Opcodes of an input beat
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // Statement kinds
    localparam logic [2:0] K_ASSIGN = 3'd0;
    localparam logic [2:0] K_PRINT  = 3'd1;
    localparam logic [2:0] K_LOCK   = 3'd2;
    localparam logic [2:0] K_UNLOCK = 3'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_ASSIGN_COST = 3'd0;
    localparam logic [2:0] CFG_PRINT_COST  = 3'd1;
    localparam logic [2:0] CFG_LOCK_COST   = 3'd2;
    localparam logic [2:0] CFG_UNLOCK_COST = 3'd3;
    localparam logic [2:0] CFG_TIME_SLICE  = 3'd4;
    localparam logic [2:0] CFG_PROC_COUNT  = 3'd5;

    typedef struct packed {
        logic [7:0] assign_cost;
        logic [7:0] print_cost;
        logic [7:0] lock_cost;
        logic [7:0] unlock_cost;
        logic [7:0] time_slice;
        logic [4:0] process_count;
    } t_cfg;

endpackage

>>> hw/rtl/rrls_prog_mem.sv
// Program store: one write port, one registered read port.
module rrls_prog_mem #(
    parameter int DEPTH = rrls_pkg::MAX_PROCS * rrls_pkg::MAX_STMTS,
    parameter int AW    = 9
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [rrls_pkg::STMT_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [rrls_pkg::STMT_W-1:0] o_rdata
);

    logic [rrls_pkg::STMT_W-1:0] r_mem [DEPTH];
    logic [rrls_pkg::STMT_W-1:0] r_rdata;

    // Write statement words
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rrls_cfg_regs.sv
// Configuration register bank of the scheduler.
module rrls_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output logic                o_cfg_ready,
    output rrls_pkg::t_cfg      o_cfg
);

    rrls_pkg::t_cfg r_cfg;

    // Take one register write per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.assign_cost   <= 8'd1;
            r_cfg.print_cost    <= 8'd1;
            r_cfg.lock_cost     <= 8'd1;
            r_cfg.unlock_cost   <= 8'd1;
            r_cfg.time_slice    <= 8'd1;
            r_cfg.process_count <= 5'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rrls_pkg::CFG_ASSIGN_COST: r_cfg.assign_cost   <= i_cfg_data;
                rrls_pkg::CFG_PRINT_COST:  r_cfg.print_cost    <= i_cfg_data;
                rrls_pkg::CFG_LOCK_COST:   r_cfg.lock_cost     <= i_cfg_data;
                rrls_pkg::CFG_UNLOCK_COST: r_cfg.unlock_cost   <= i_cfg_data;
                rrls_pkg::CFG_TIME_SLICE:  r_cfg.time_slice    <= i_cfg_data;
                rrls_pkg::CFG_PROC_COUNT:  r_cfg.process_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

>>> hw/rtl/round_robin_lock_scheduler.sv
// Round-robin lock scheduler top level: queues, run state and step execution.
//
// Load and start beats take effect as they are accepted. A step beat is
// split: in the accept cycle the head of the ready queue is dispatched if
// nothing runs and the program store is read at that process's counter;
// then, in the execute state, the returned statement is executed against the
// variables, lock and queues and the result beat is loaded into the output
// register. The registered read of the program store sets this split. A load
// never shares a cycle with a step read, so no forwarding is needed.
// Input is stalled while a step executes or a result waits to be taken.
module round_robin_lock_scheduler #(
    parameter int MAX_PROCS = rrls_pkg::MAX_PROCS,
    parameter int MAX_STMTS = rrls_pkg::MAX_STMTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [4:0] i_proc_id,
    input  logic [4:0] i_slot,
    input  logic [2:0] i_stmt_kind,
    input  logic [4:0] i_var_index,
    input  logic [6:0] i_const_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_printed,
    output logic [4:0] o_print_proc,
    output logic [6:0] o_print_value,
    output logic       o_all_done,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int QW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int ID_W  = $clog2(MAX_PROCS + 1);
    localparam int PC_W  = (MAX_STMTS > 1) ? $clog2(MAX_STMTS) : 1;
    localparam int DEPTH = MAX_PROCS * MAX_STMTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NV    = rrls_pkg::NUM_VARS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    rrls_pkg::t_cfg w_cfg;

    logic [0:0]      r_state, n_state;
    logic [ID_W-1:0] r_cur, n_cur;
    logic [7:0]      r_time, n_time;
    logic            r_lock, n_lock;
    logic [PC_W-1:0] r_pc [MAX_PROCS];
    logic [PC_W-1:0] n_pc [MAX_PROCS];
    logic [6:0]      r_var [NV];
    logic [6:0]      n_var [NV];
    logic [ID_W-1:0] r_rq [MAX_PROCS];
    logic [ID_W-1:0] n_rq [MAX_PROCS];
    logic [QW-1:0]   r_rq_head, n_rq_head;
    logic [ID_W-1:0] r_rq_cnt, n_rq_cnt;
    logic [ID_W-1:0] r_bq [MAX_PROCS];
    logic [ID_W-1:0] n_bq [MAX_PROCS];
    logic [QW-1:0]   r_bq_head, n_bq_head;
    logic [ID_W-1:0] r_bq_cnt, n_bq_cnt;
    logic            r_out_valid, n_out_valid;
    logic            r_out_printed, n_out_printed;
    logic [4:0]      r_out_proc, n_out_proc;
    logic [6:0]      r_out_val, n_out_val;
    logic            r_out_done, n_out_done;

    logic                        w_fire;
    logic                        w_disp;
    logic [ID_W-1:0]             w_dcur;
    logic [QW-1:0]               w_didx;
    logic [AW-1:0]               w_raddr;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [rrls_pkg::STMT_W-1:0] w_wdata;
    logic [rrls_pkg::STMT_W-1:0] w_rdata;

    // Index of the entry c places after head, wrapped at the queue depth
    function automatic logic [QW-1:0] f_qadd(input logic [QW-1:0] h, input int c);
        int s;
        s = int'(h) + c;
        if (s >= MAX_PROCS) begin
            s = s - MAX_PROCS;
        end
        return QW'(s);
    endfunction

    // Time left after a charge, floored at zero
    function automatic logic [7:0] f_charge(input logic [7:0] t, input logic [7:0] cost);
        return (cost >= t) ? 8'd0 : t - cost;
    endfunction

    rrls_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // Accept only when idle and the output register will be free
    assign o_stall = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign w_fire  = i_valid && !o_stall;

    // Dispatch the ready head when nothing runs
    assign w_disp  = (r_cur == '0) && (r_rq_cnt != '0);
    assign w_dcur  = w_disp ? r_rq[r_rq_head] : r_cur;
    assign w_didx  = QW'(w_dcur - ID_W'(1));
    assign w_raddr = AW'(AW'(w_didx) * AW'(MAX_STMTS)) + AW'(r_pc[w_didx]);

    // Store a loaded statement when its address is in range
    assign w_we = w_fire && (i_opcode == rrls_pkg::OP_LOAD) && (i_proc_id != 5'd0)
                  && (int'(i_proc_id) <= MAX_PROCS) && (int'(i_slot) < MAX_STMTS);
    assign w_waddr = AW'(AW'(QW'(i_proc_id - 5'd1)) * AW'(MAX_STMTS)) + AW'(i_slot);
    assign w_wdata = {i_stmt_kind, i_var_index, i_const_value};

    rrls_prog_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next run state
    always_comb begin
        logic [2:0]    k;
        logic [4:0]    v;
        logic [6:0]    c;
        logic          adv;
        logic          leave;
        logic [QW-1:0] idx;
        logic [ID_W-1:0] b;
        int            n;

        n_state       = r_state;
        n_cur         = r_cur;
        n_time        = r_time;
        n_lock        = r_lock;
        n_pc          = r_pc;
        n_var         = r_var;
        n_rq          = r_rq;
        n_rq_head     = r_rq_head;
        n_rq_cnt      = r_rq_cnt;
        n_bq          = r_bq;
        n_bq_head     = r_bq_head;
        n_bq_cnt      = r_bq_cnt;
        n_out_valid   = r_out_valid && i_stall;
        n_out_printed = r_out_printed;
        n_out_proc    = r_out_proc;
        n_out_val     = r_out_val;
        n_out_done    = r_out_done;
        k     = w_rdata[14:12];
        v     = w_rdata[11:7];
        c     = w_rdata[6:0];
        adv   = 1'b1;
        leave = 1'b0;
        idx   = QW'(r_cur - ID_W'(1));
        b     = '0;
        n     = 0;

        case (r_state)
            ST_IDLE: begin
                if (w_fire && (i_opcode == rrls_pkg::OP_START)) begin
                    // Clear the run and queue processes 1..n
                    n = (int'(w_cfg.process_count) > MAX_PROCS) ? MAX_PROCS
                        : int'(w_cfg.process_count);
                    for (int i = 0; i < MAX_PROCS; i++) begin
                        n_pc[i] = '0;
                        n_rq[i] = ID_W'(i + 1);
                    end
                    for (int i = 0; i < NV; i++) begin
                        n_var[i] = '0;
                    end
                    n_rq_head = '0;
                    n_rq_cnt  = ID_W'(n);
                    n_bq_head = '0;
                    n_bq_cnt  = '0;
                    n_lock    = 1'b0;
                    n_cur     = '0;
                    n_time    = '0;
                end else if (w_fire && (i_opcode == rrls_pkg::OP_STEP)) begin
                    // Dispatch and start the statement read
                    n_state = ST_EXEC;
                    if (w_disp) begin
                        n_cur     = w_dcur;
                        n_time    = (w_cfg.time_slice == 8'd0) ? 8'd1 : w_cfg.time_slice;
                        n_rq_head = f_qadd(r_rq_head, 1);
                        n_rq_cnt  = r_rq_cnt - ID_W'(1);
                    end
                end
            end
            ST_EXEC: begin
                n_state       = ST_IDLE;
                n_out_valid   = 1'b1;
                n_out_printed = 1'b0;
                n_out_proc    = '0;
                n_out_val     = '0;
                if (r_cur != '0) begin
                    case (k)
                        rrls_pkg::K_ASSIGN: begin
                            if (int'(v) < NV) begin
                                n_var[v] = c;
                            end
                            n_time = f_charge(r_time, w_cfg.assign_cost);
                        end
                        rrls_pkg::K_PRINT: begin
                            n_out_printed = 1'b1;
                            n_out_proc    = 5'(r_cur);
                            n_out_val     = (int'(v) < NV) ? r_var[v] : 7'd0;
                            n_time        = f_charge(r_time, w_cfg.print_cost);
                        end
                        rrls_pkg::K_LOCK: begin
                            n_time = f_charge(r_time, w_cfg.lock_cost);
                            if (r_lock) begin
                                // Park on the blocked queue and retry later
                                if (int'(r_bq_cnt) < MAX_PROCS) begin
                                    n_bq[f_qadd(r_bq_head, int'(r_bq_cnt))] = r_cur;
                                    n_bq_cnt = r_bq_cnt + ID_W'(1);
                                end
                                adv   = 1'b0;
                                leave = 1'b1;
                            end else begin
                                n_lock = 1'b1;
                            end
                        end
                        rrls_pkg::K_UNLOCK: begin
                            n_lock = 1'b0;
                            n_time = f_charge(r_time, w_cfg.unlock_cost);
                            // Wake the blocked head at the ready front
                            if (r_bq_cnt != '0) begin
                                b         = r_bq[r_bq_head];
                                n_bq_head = f_qadd(r_bq_head, 1);
                                n_bq_cnt  = r_bq_cnt - ID_W'(1);
                                if (int'(n_rq_cnt) < MAX_PROCS) begin
                                    n_rq_head       = f_qadd(n_rq_head, MAX_PROCS - 1);
                                    n_rq[n_rq_head] = b;
                                    n_rq_cnt        = n_rq_cnt + ID_W'(1);
                                end
                            end
                        end
                        default: begin
                            adv   = 1'b0;
                            leave = 1'b1;
                        end
                    endcase
                    if (adv) begin
                        n_pc[idx] = (r_pc[idx] == PC_W'(MAX_STMTS - 1)) ? '0
                                    : r_pc[idx] + PC_W'(1);
                    end
                    if (leave) begin
                        n_cur  = '0;
                        n_time = '0;
                    end else if (n_time == 8'd0) begin
                        // Quantum spent: back of the ready queue
                        if (int'(n_rq_cnt) < MAX_PROCS) begin
                            n_rq[f_qadd(n_rq_head, int'(n_rq_cnt))] = r_cur;
                            n_rq_cnt = n_rq_cnt + ID_W'(1);
                        end
                        n_cur = '0;
                    end
                end
                n_out_done = (n_rq_cnt == '0) && (n_cur == '0);
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_time      <= '0;
            r_lock      <= 1'b0;
            r_rq_head   <= '0;
            r_rq_cnt    <= '0;
            r_bq_head   <= '0;
            r_bq_cnt    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++) begin
                r_pc[i] <= '0;
            end
            for (int i = 0; i < NV; i++) begin
                r_var[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_time      <= n_time;
            r_lock      <= n_lock;
            r_rq_head   <= n_rq_head;
            r_rq_cnt    <= n_rq_cnt;
            r_bq_head   <= n_bq_head;
            r_bq_cnt    <= n_bq_cnt;
            r_out_valid <= n_out_valid;
            r_pc        <= n_pc;
            r_var       <= n_var;
        end
    end

    // Queue entries and result payload
    always_ff @(posedge i_clk) begin
        r_rq          <= n_rq;
        r_bq          <= n_bq;
        r_out_printed <= n_out_printed;
        r_out_proc    <= n_out_proc;
        r_out_val     <= n_out_val;
        r_out_done    <= n_out_done;
    end

    assign o_valid       = r_out_valid;
    assign o_printed     = r_out_printed;
    assign o_print_proc  = r_out_proc;
    assign o_print_value = r_out_val;
    assign o_all_done    = r_out_done;

`include "round_robin_lock_scheduler_assert.svh"

    `RRLS_ASSERT_NEXT(a_step_exec, w_fire && (i_opcode == rrls_pkg::OP_STEP), r_state == ST_EXEC)
    `RRLS_ASSERT_NEXT(a_exec_result, r_state == ST_EXEC, r_out_valid && (r_state == ST_IDLE))
    `RRLS_ASSERT_NOW(a_proc_budget, 1'b1,
        (int'(r_rq_cnt) + int'(r_bq_cnt) + ((r_cur != '0) ? 1 : 0)) <= MAX_PROCS)
    `RRLS_ASSERT_NOW(a_no_load_in_exec, r_state == ST_EXEC, !w_we)

endmodule
